// ===== sv/assert_macros.svh =====
// Assertion macros used by the top level of the LZW encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/gle_pkg.sv =====
// Types and constants shared by the LZW encoder controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

package gle_pkg;

    localparam int CODE_W  = 12;
    localparam int PIX_W   = 8;
    localparam int KEY_W   = 20;
    localparam int WIDTH_W = 4;
    localparam int NFC_W   = 13;
    localparam int ACC_W   = 19;
    localparam int CNT_W   = 5;
    localparam int EPOCH_W = 4;

    localparam logic [CODE_W-1:0]  CODE_CLEAR = 12'd256;
    localparam logic [CODE_W-1:0]  CODE_END   = 12'd257;
    localparam logic [NFC_W-1:0]   CODE_FIRST = 13'd258;
    localparam logic [NFC_W-1:0]   CODE_LIMIT = 13'd4096;
    localparam logic [WIDTH_W-1:0] WIDTH_MIN  = 4'd9;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX  = 4'd12;
    localparam logic [31:0]        HASH_MULT  = 32'd2654435761;

    typedef enum logic [1:0] {
        SEL_CLEAR,
        SEL_PREFIX,
        SEL_END
    } code_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WIPE,
        ST_HEAD,
        ST_LOOKUP,
        ST_HASH,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_MISS,
        ST_MISS_UPD,
        ST_EOF_CHK,
        ST_EOF_END,
        ST_FLUSH,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic      latch_in;
        logic      put;
        code_sel_t put_sel;
        logic      set_clear_sent;
        logic      load_prefix_pix;
        logic      load_prefix_hit;
        logic      load_key;
        logic      load_hash;
        logic      rd_en;
        logic      slot_inc;
        logic      add_entry;
        logic      table_clear;
        logic      frame_reset;
        logic      drain;
        logic      last_mark;
        logic      flush;
        logic      wipe_en;
    } cmd_t;

    typedef struct packed {
        logic clear_sent;
        logic prefix_valid;
        logic eof;
        logic used;
        logic hit;
        logic full;
        logic count_ge8;
        logic count_nz;
        logic out_free;
        logic wipe_last;
        logic wipe_pending;
    } status_t;

endpackage

`default_nettype wire

// ===== sv/gle_dpath.sv =====
// Datapath of the LZW encoder: prefix state, hash table memory, bit packer, output register.
`timescale 1ns / 1ps
`default_nettype none

module gle_dpath #(
    parameter int HASH_SLOTS = 8192
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [7:0]            pixel_index,
    input  wire logic                  end_of_frame,
    input  wire gle_pkg::cmd_t         cmd,
    output gle_pkg::status_t           status,
    input  wire logic                  byte_ready,
    output logic                       byte_valid,
    output logic [7:0]                 packed_byte,
    output logic                       last_byte
);
    import gle_pkg::*;

    localparam int SLOT_W = $clog2(HASH_SLOTS);
    localparam int WORD_W = EPOCH_W + KEY_W + CODE_W;
    localparam logic [SLOT_W-1:0] K_LO = HASH_MULT[SLOT_W-1:0];

    logic [PIX_W-1:0]   pix_reg, pix_next;
    logic               eof_reg, eof_next;
    logic [CODE_W-1:0]  prefix_reg, prefix_next;
    logic               prefix_valid_reg, prefix_valid_next;
    logic               clear_sent_reg, clear_sent_next;
    logic [WIDTH_W-1:0] width_reg, width_next;
    logic [NFC_W-1:0]   nfc_reg, nfc_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic               wipe_pending_reg, wipe_pending_next;
    logic [SLOT_W-1:0]  wipe_addr_reg, wipe_addr_next;
    logic               ovalid_reg, ovalid_next;
    logic [7:0]         obyte_reg, obyte_next;
    logic               olast_reg, olast_next;
    logic [WORD_W-1:0]  rd_reg;

    logic [WORD_W-1:0]  mem [HASH_SLOTS];

    logic [CODE_W-1:0]  put_code;
    logic [SLOT_W-1:0]  hash_slot;
    logic [EPOCH_W-1:0] rd_epoch;
    logic [KEY_W-1:0]   rd_key;
    logic [CODE_W-1:0]  rd_code;
    logic               out_free;

    assign rd_epoch  = rd_reg[WORD_W-1 -: EPOCH_W];
    assign rd_key    = rd_reg[CODE_W +: KEY_W];
    assign rd_code   = rd_reg[CODE_W-1:0];
    assign hash_slot = key_reg[SLOT_W-1:0] * K_LO;
    assign out_free  = !ovalid_reg || byte_ready;

    always_comb
    begin
        case (cmd.put_sel)
            SEL_CLEAR:  put_code = CODE_CLEAR;
            SEL_PREFIX: put_code = prefix_reg;
            SEL_END:    put_code = CODE_END;
            default:    put_code = CODE_CLEAR;
        endcase
    end

    always_comb
    begin
        pix_next          = pix_reg;
        eof_next          = eof_reg;
        prefix_next       = prefix_reg;
        prefix_valid_next = prefix_valid_reg;
        clear_sent_next   = clear_sent_reg;
        width_next        = width_reg;
        nfc_next          = nfc_reg;
        acc_next          = acc_reg;
        cnt_next          = cnt_reg;
        key_next          = key_reg;
        slot_next         = slot_reg;
        epoch_next        = epoch_reg;
        wipe_pending_next = wipe_pending_reg;
        wipe_addr_next    = wipe_addr_reg;
        ovalid_next       = ovalid_reg;
        obyte_next        = obyte_reg;
        olast_next        = olast_reg;

        if (cmd.latch_in)
        begin
            pix_next = pixel_index;
            eof_next = end_of_frame;
        end
        if (cmd.set_clear_sent)
            clear_sent_next = 1'b1;
        if (cmd.load_prefix_pix)
        begin
            prefix_next       = CODE_W'(pix_reg);
            prefix_valid_next = 1'b1;
        end
        if (cmd.load_prefix_hit)
            prefix_next = rd_code;
        if (cmd.load_key)
            key_next = {prefix_reg, pix_reg};
        if (cmd.load_hash)
            slot_next = hash_slot;
        if (cmd.slot_inc)
            slot_next = slot_reg + 1'b1;
        if (cmd.put)
        begin
            acc_next = acc_reg | (ACC_W'(put_code) << cnt_reg);
            cnt_next = cnt_reg + CNT_W'(width_reg);
        end
        if (cmd.drain)
        begin
            acc_next = acc_reg >> 8;
            cnt_next = cnt_reg - CNT_W'(8);
        end
        if (cmd.add_entry)
        begin
            if (nfc_reg == (NFC_W'(1) << width_reg) && width_reg < WIDTH_MAX)
                width_next = width_reg + 1'b1;
            nfc_next = nfc_reg + 1'b1;
        end
        if (cmd.table_clear || cmd.frame_reset)
        begin
            width_next = WIDTH_MIN;
            nfc_next   = CODE_FIRST;
            // Retire every entry by moving to a new epoch; wipe when it runs out.
            if (epoch_reg == '1)
                wipe_pending_next = 1'b1;
            else
                epoch_next = epoch_reg + 1'b1;
        end
        if (cmd.frame_reset)
        begin
            prefix_next       = '0;
            prefix_valid_next = 1'b0;
            clear_sent_next   = 1'b0;
            acc_next          = '0;
            cnt_next          = '0;
        end
        if (cmd.wipe_en)
        begin
            wipe_addr_next = wipe_addr_reg + 1'b1;
            if (wipe_addr_reg == '1)
            begin
                epoch_next        = EPOCH_W'(1);
                wipe_pending_next = 1'b0;
            end
        end
        if (cmd.drain || cmd.flush)
        begin
            ovalid_next = 1'b1;
            obyte_next  = acc_reg[7:0];
            olast_next  = cmd.flush || (cmd.last_mark && cnt_reg == CNT_W'(8));
        end
        else if (byte_ready)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg       <= '0;
            prefix_valid_reg <= 1'b0;
            clear_sent_reg   <= 1'b0;
            width_reg        <= WIDTH_MIN;
            nfc_reg          <= CODE_FIRST;
            acc_reg          <= '0;
            cnt_reg          <= '0;
            epoch_reg        <= '0;
            wipe_pending_reg <= 1'b1;
            wipe_addr_reg    <= '0;
            ovalid_reg       <= 1'b0;
        end
        else
        begin
            prefix_reg       <= prefix_next;
            prefix_valid_reg <= prefix_valid_next;
            clear_sent_reg   <= clear_sent_next;
            width_reg        <= width_next;
            nfc_reg          <= nfc_next;
            acc_reg          <= acc_next;
            cnt_reg          <= cnt_next;
            epoch_reg        <= epoch_next;
            wipe_pending_reg <= wipe_pending_next;
            wipe_addr_reg    <= wipe_addr_next;
            ovalid_reg       <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg   <= pix_next;
        eof_reg   <= eof_next;
        key_reg   <= key_next;
        slot_reg  <= slot_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wipe_en)
            mem[wipe_addr_reg] <= '0;
        else if (cmd.add_entry)
            mem[slot_reg] <= {epoch_reg, key_reg, nfc_reg[CODE_W-1:0]};
        if (cmd.rd_en)
            rd_reg <= mem[slot_reg];
    end

    assign status.clear_sent   = clear_sent_reg;
    assign status.prefix_valid = prefix_valid_reg;
    assign status.eof          = eof_reg;
    assign status.used         = (rd_epoch == epoch_reg);
    assign status.hit          = (rd_key == key_reg);
    assign status.full         = (nfc_reg == CODE_LIMIT);
    assign status.count_ge8    = (cnt_reg >= CNT_W'(8));
    assign status.count_nz     = (cnt_reg != '0);
    assign status.out_free     = out_free;
    assign status.wipe_last    = (wipe_addr_reg == '1);
    assign status.wipe_pending = wipe_pending_reg;

    assign byte_valid  = ovalid_reg;
    assign packed_byte = obyte_reg;
    assign last_byte   = olast_reg;

endmodule

`default_nettype wire

// ===== sv/gle_ctrl.sv =====
// Controller state machine of the LZW encoder.
`timescale 1ns / 1ps
`default_nettype none

module gle_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pixel_valid,
    output logic                   pixel_ready,
    input  wire gle_pkg::status_t  status,
    output gle_pkg::cmd_t          cmd
);
    import gle_pkg::*;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            ST_IDLE:
                if (status.wipe_pending)
                    state_next = ST_WIPE;
                else if (pixel_valid)
                    state_next = ST_HEAD;
            ST_WIPE:
                if (status.wipe_last)
                    state_next = ST_IDLE;
            ST_HEAD:
                if (!status.clear_sent)
                begin
                    ret_next   = ST_LOOKUP;
                    state_next = ST_DRAIN;
                end
                else
                    state_next = ST_LOOKUP;
            ST_LOOKUP:
                state_next = status.prefix_valid ? ST_HASH : ST_EOF_CHK;
            ST_HASH:
                state_next = ST_PROBE_RD;
            ST_PROBE_RD:
                state_next = ST_PROBE_CHK;
            ST_PROBE_CHK:
                if (!status.used)
                    state_next = ST_MISS;
                else if (status.hit)
                    state_next = ST_EOF_CHK;
                else
                    state_next = ST_PROBE_RD;
            ST_MISS:
            begin
                ret_next   = ST_MISS_UPD;
                state_next = ST_DRAIN;
            end
            ST_MISS_UPD:
                if (!status.full)
                    state_next = ST_EOF_CHK;
                else
                begin
                    ret_next   = ST_EOF_CHK;
                    state_next = ST_DRAIN;
                end
            ST_EOF_CHK:
                if (status.eof)
                begin
                    ret_next   = ST_EOF_END;
                    state_next = ST_DRAIN;
                end
                else
                    state_next = ST_IDLE;
            ST_EOF_END:
            begin
                ret_next   = ST_FLUSH;
                state_next = ST_DRAIN;
            end
            ST_FLUSH:
                if (!status.count_nz || status.out_free)
                    state_next = ST_IDLE;
            ST_DRAIN:
                if (!status.count_ge8)
                    state_next = ret_reg;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.put_sel = SEL_CLEAR;
        pixel_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pixel_ready  = !status.wipe_pending;
                cmd.latch_in = pixel_valid && !status.wipe_pending;
            end
            ST_WIPE:
                cmd.wipe_en = 1'b1;
            ST_HEAD:
                if (!status.clear_sent)
                begin
                    cmd.put            = 1'b1;
                    cmd.put_sel        = SEL_CLEAR;
                    cmd.set_clear_sent = 1'b1;
                end
            ST_LOOKUP:
                if (status.prefix_valid)
                    cmd.load_key = 1'b1;
                else
                    cmd.load_prefix_pix = 1'b1;
            ST_HASH:
                cmd.load_hash = 1'b1;
            ST_PROBE_RD:
                cmd.rd_en = 1'b1;
            ST_PROBE_CHK:
                if (status.used)
                begin
                    if (status.hit)
                        cmd.load_prefix_hit = 1'b1;
                    else
                        cmd.slot_inc = 1'b1;
                end
            ST_MISS:
            begin
                cmd.put     = 1'b1;
                cmd.put_sel = SEL_PREFIX;
            end
            ST_MISS_UPD:
            begin
                cmd.load_prefix_pix = 1'b1;
                if (!status.full)
                    cmd.add_entry = 1'b1;
                else
                begin
                    cmd.put         = 1'b1;
                    cmd.put_sel     = SEL_CLEAR;
                    cmd.table_clear = 1'b1;
                end
            end
            ST_EOF_CHK:
                if (status.eof)
                begin
                    cmd.put     = 1'b1;
                    cmd.put_sel = SEL_PREFIX;
                end
            ST_EOF_END:
            begin
                cmd.put     = 1'b1;
                cmd.put_sel = SEL_END;
            end
            ST_FLUSH:
                if (!status.count_nz)
                    cmd.frame_reset = 1'b1;
                else if (status.out_free)
                begin
                    cmd.flush       = 1'b1;
                    cmd.frame_reset = 1'b1;
                end
            ST_DRAIN:
            begin
                cmd.drain     = status.count_ge8 && status.out_free;
                cmd.last_mark = (ret_reg == ST_FLUSH);
            end
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/gif_lzw_encoder_core.sv =====
// Top level of the GIF LZW encoder: controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// GIF LZW encoder, minimum code size 8 (clear 256, end 257, widths 9 to 12).
// Pixel channel: pixel_valid/pixel_ready carry pixel_index and end_of_frame;
// a transfer takes one palette index, end_of_frame marks the frame's last one.
// Byte channel: byte_valid/byte_ready carry packed_byte, the LSB-first packed
// code stream; last_byte flags the final byte of a frame, zero-padded where the codes end mid-byte.
// One pixel is worked at a time. A dictionary hit runs the head, lookup, hash,
// probe read and probe check steps; each further probe of the open-addressed
// table repeats read and check (one read port, one probe per read); a miss adds the
// miss, update and per-byte drain steps. Read latency and probe chains set the rate.
// The output byte sits in a register, so the next pixel transfer is taken
// while that byte still waits; a stalled receiver holds the block only when a
// second byte must be emitted.
// Reset clears all frame state, then a wipe pass over all HASH_SLOTS entries
// (one per cycle) runs before the first pixel transfer. Dictionary clears bump
// an epoch mark instead, as frame ends do; every 15th of these repeats the wipe pass.
// HASH_SLOTS must be a power of two.
module gif_lzw_encoder_core #(
    parameter int HASH_SLOTS = 8192
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       pixel_valid,
    output logic            pixel_ready,
    input  wire logic [7:0] pixel_index,
    input  wire logic       end_of_frame,
    output logic            byte_valid,
    input  wire logic       byte_ready,
    output logic [7:0]      packed_byte,
    output logic            last_byte
);
    import gle_pkg::*;

    `include "assert_macros.svh"

    cmd_t    cmd;
    status_t status;

    // Sequence the clear code, probe, miss update and end-of-frame steps.
    gle_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .status      (status),
        .cmd         (cmd)
    );

    // Hold the dictionary, the prefix and the bit packer.
    gle_dpath #(
        .HASH_SLOTS (HASH_SLOTS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_index  (pixel_index),
        .end_of_frame (end_of_frame),
        .cmd          (cmd),
        .status       (status),
        .byte_ready   (byte_ready),
        .byte_valid   (byte_valid),
        .packed_byte  (packed_byte),
        .last_byte    (last_byte)
    );

    `ASSERT_IMP(a_no_pixel_during_wipe, clk, rst_n, pixel_ready, !status.wipe_pending)
    `ASSERT_IMP(a_drain_full_byte, clk, rst_n, cmd.drain, status.count_ge8)
    `ASSERT_IMP(a_no_byte_overwrite, clk, rst_n, cmd.drain || cmd.flush, status.out_free)
    `ASSERT_NXT(a_frame_reset_drops_prefix, clk, rst_n, cmd.frame_reset, !status.prefix_valid)

endmodule

`default_nettype wire
